// ===== sv/sts_pkg.sv =====
package sts_pkg;

  localparam int SCREEN_LIMIT = 4096;
  localparam int FILTER_HALF  = 16;
  localparam int DIV_BITS     = 20;

  typedef struct packed {
    logic [1:0]         siz;
    logic [7:0]         tw;
    logic [7:0]         th;
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic [12:0]        w;
    logic [12:0]        h;
    logic               filt;
  } req_t;

  typedef struct packed {
    logic [12:0]        rect_left;
    logic [12:0]        rect_top;
    logic [13:0]        rect_right;
    logic [13:0]        rect_bottom;
    logic signed [26:0] s_start;
    logic signed [26:0] t_start;
    logic [13:0]        load_cols;
    logic [13:0]        load_rows;
    logic [6:0]         row_words;
    logic [39:0]        scale_steps;
  } res_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV_START, B_DIV_WAIT, B_ROW_CHK, B_ROW_FIN,
    B_COL_CHK, B_COL_FIN, B_EMIT, B_FLUSH
  } bstate_t;

  typedef enum logic [2:0] {J_DSDX, J_DTDY, J_YL, J_YH, J_XL, J_XH} job_t;

  function automatic logic [7:0] chunk_w(input logic [1:0] siz);
    logic [7:0] r;
    case (siz)
      2'd0: r = 8'd128;
      2'd1: r = 8'd64;
      2'd2: r = 8'd64;
      default: r = 8'd32;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chunk_h(input logic [1:0] siz);
    logic [7:0] r;
    case (siz)
      2'd0: r = 8'd64;
      2'd1: r = 8'd64;
      2'd2: r = 8'd32;
      default: r = 8'd32;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sprite_tile_splitter.sv =====
// sequence: the two scale steps are divided first, then the row edges for each row of
//   chunks and the column edges for each chunk of a visible row; all divisions share one divider
// a chunk is held back one slot and leaves when the next one is found or the sprite ends
// flow: the back end handles one sprite at a time;
//   empty textures cost nothing there, a further request waits in a two-entry queue
// reset: rst synchronous active high, clears filter_on, the queue and all handshakes
module sprite_tile_splitter #(
  parameter int MAX_TEX_DIM = 128
) (
  input  logic         clk,
  input  logic         rst,
  // configuration: filter_on register
  input  logic         cfg_wen,
  input  logic         cfg_wdata,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // texel_size_code[1:0], tex_width[9:2], tex_height[17:10], screen_x[31:18],
  // screen_y[45:32], draw_width[58:46], draw_height[71:59]
  input  logic [71:0]  s_axis_tdata,
  // chunk stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rect_left[12:0], rect_top[25:13], rect_right[39:26], rect_bottom[53:40],
  // s_start[80:54], t_start[107:81], load_cols[121:108], load_rows[135:122],
  // row_words[142:136], scale_steps[182:143], zero pad[183]
  output logic [183:0] m_axis_tdata,
  // last_chunk
  output logic         m_axis_tlast
);
  import sts_pkg::*;

  req_t front_req;
  req_t q_head;
  res_t res;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;

  // front: filter_on register, saturation of texture size, drop of empty textures
  sts_front #(
    .MAX_TEX_DIM (MAX_TEX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .req       (front_req)
  );

  // decoupling queue between front and chunk walker
  sts_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (front_req),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: steps, chunk walk, clipping; holds one chunk back to mark the last one
  sts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req       (q_head),
    .req_avail (~q_empty),
    .req_pop   (q_pop),
    .res       (res),
    .res_last  (m_axis_tlast),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res.scale_steps, res.row_words, res.load_rows,
                         res.load_cols, res.t_start, res.s_start, res.rect_bottom,
                         res.rect_right, res.rect_top, res.rect_left};

endmodule

// ===== sv/sts_div.sv =====
module sts_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] num,
  input  logic [12:0] den,
  output logic        done,
  output logic [19:0] quo
);
  import sts_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'(DIV_BITS - 1);

  logic        busy;
  logic [4:0]  cnt;
  logic [12:0] rem;
  logic [12:0] dvs;
  logic [13:0] trial;
  logic [13:0] diff;
  logic        ge;

  // one quotient bit per cycle; a zero divisor gives all ones
  assign trial = {rem, quo[19]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= ge ? diff[12:0] : trial[12:0];
      quo <= {quo[18:0], ge};
    end
  end

endmodule

// ===== sv/sts_fifo.sv =====
module sts_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sts_pkg::req_t din,
  input  logic          pop,
  output sts_pkg::req_t dout,
  output logic          full,
  output logic          empty
);
  import sts_pkg::*;

  req_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/sts_front.sv =====
module sts_front #(
  parameter int MAX_TEX_DIM = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [71:0]   in_data,
  input  logic          q_full,
  output logic          q_push,
  output sts_pkg::req_t req
);
  import sts_pkg::*;

  localparam logic [7:0] MAX_DIM = 8'(MAX_TEX_DIM);

  logic       filter_on;
  logic [7:0] tw_in;
  logic [7:0] th_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_on <= 1'b0;
    end else if (cfg_wen) begin
      filter_on <= cfg_wdata;
    end
  end

  assign tw_in = in_data[9:2];
  assign th_in = in_data[17:10];

  always_comb begin
    req.siz  = in_data[1:0];
    req.tw   = (tw_in > MAX_DIM) ? MAX_DIM : tw_in;
    req.th   = (th_in > MAX_DIM) ? MAX_DIM : th_in;
    req.x    = in_data[31:18];
    req.y    = in_data[45:32];
    req.w    = in_data[58:46];
    req.h    = in_data[71:59];
    req.filt = filter_on;
  end

  // empty textures are dropped here and never reach the queue
  assign in_ready = ~q_full;
  assign q_push   = in_valid & in_ready & (tw_in != 8'd0) & (th_in != 8'd0);

endmodule

// ===== sv/sts_back.sv =====
module sts_back (
  input  logic          clk,
  input  logic          rst,
  input  sts_pkg::req_t req,
  input  logic          req_avail,
  output logic          req_pop,
  output sts_pkg::res_t res,
  output logic          res_last,
  output logic          res_valid,
  input  logic          res_ready
);
  import sts_pkg::*;

  bstate_t state;
  bstate_t state_next;
  job_t    job;

  req_t               cur;
  logic [19:0]        dsdx;
  logic [19:0]        dtdy;
  logic [7:0]         ty;
  logic [7:0]         tx;
  logic signed [14:0] yl_r;
  logic signed [14:0] yh_r;
  logic signed [14:0] xl_r;
  logic signed [14:0] xh_r;
  logic signed [35:0] prod_r;
  logic [12:0]        rt_r;
  logic [13:0]        rb_r;
  logic [26:0]        t_r;
  logic [13:0]        lrows_r;
  res_t               new_r;
  res_t               held;
  logic               held_valid;

  logic        div_start;
  logic        div_done;
  logic [19:0] div_q;
  logic [19:0] div_num;
  logic [12:0] div_den;

  logic [7:0]  cw;
  logic [7:0]  ch;
  logic [8:0]  ty_sum;
  logic [8:0]  tx_sum;
  logic [7:0]  lrt;
  logic [7:0]  lrs;
  logic        row_done;
  logic        col_done;
  logic        slot_free;
  logic        emit_go;
  logic        res_load;
  logic [14:0] edge_q;
  logic [14:0] y_edge;
  logic [14:0] x_edge;
  logic [29:0] adv;
  logic [29:0] coord;
  logic [29:0] base;
  logic [7:0]  near_l;
  logic [7:0]  far_l;
  logic [7:0]  span;
  logic [10:0] span_sh;
  logic [10:0] line;
  logic        row_vis;
  logic        col_vis;

  sts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign cw       = chunk_w(cur.siz) >> cur.filt;
  assign ch       = chunk_h(cur.siz);
  assign ty_sum   = {1'b0, ty} + {1'b0, ch};
  assign tx_sum   = {1'b0, tx} + {1'b0, cw};
  assign lrt      = (ty_sum > {1'b0, cur.th}) ? cur.th : ty_sum[7:0];
  assign lrs      = (tx_sum > {1'b0, cur.tw}) ? cur.tw : tx_sum[7:0];
  assign row_done = ty_sum >= {1'b0, cur.th};
  assign col_done = tx_sum >= {1'b0, cur.tw};
  assign slot_free = ~res_valid | res_ready;
  assign emit_go   = ~held_valid | slot_free;
  assign res_load  = ((state == B_EMIT) || (state == B_FLUSH)) && emit_go && held_valid;
  assign row_vis  = ~((yl_r > 15'sd4096) || (yh_r < 15'sd0));
  assign col_vis  = ~((xl_r > 15'sd4096) || (xh_r < 15'sd0));

  // operand select for the shared divider
  always_comb begin
    case (job)
      J_DSDX: begin
        div_num = {cur.tw, 12'd0} + 20'(cur.w >> 1);
        div_den = cur.w;
      end
      J_DTDY: begin
        div_num = {cur.th, 12'd0} + 20'(cur.h >> 1);
        div_den = cur.h;
      end
      J_YL: begin
        div_num = {12'd0, ty} * cur.h;
        div_den = {5'd0, cur.th};
      end
      J_YH: begin
        div_num = {12'd0, lrt} * cur.h;
        div_den = {5'd0, cur.th};
      end
      J_XL: begin
        div_num = {12'd0, tx} * cur.w;
        div_den = {5'd0, cur.tw};
      end
      J_XH: begin
        div_num = {12'd0, lrs} * cur.w;
        div_den = {5'd0, cur.tw};
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign edge_q = {2'b00, div_q[12:0]};
  assign y_edge = {cur.y[13], cur.y} + edge_q;
  assign x_edge = {cur.x[13], cur.x} + edge_q;
  assign adv    = {prod_r[35], prod_r[35:7]};

  // start coordinate, edge clip and load bounds for the row or column in hand
  always_comb begin
    if (state == B_ROW_FIN) begin
      base   = {17'd0, ty, 5'd0};
      coord  = base - ((yl_r < 15'sd0) ? adv : 30'd0)
               - (cur.filt ? 30'(FILTER_HALF) : 30'd0);
      near_l = (cur.filt && ty != 8'd0) ? ty - 8'd1 : ty;
      far_l  = (cur.filt && lrt < cur.th) ? lrt + 8'd1 : lrt;
    end else begin
      base   = {17'd0, tx, 5'd0};
      coord  = base - ((xl_r < 15'sd0) ? adv : 30'd0)
               - (cur.filt ? 30'(FILTER_HALF) : 30'd0);
      near_l = (cur.filt && tx != 8'd0) ? tx - 8'd1 : tx;
      far_l  = (cur.filt && lrs < cur.tw) ? lrs + 8'd1 : lrs;
    end
    span    = far_l - near_l;
    span_sh = {3'd0, span} << cur.siz;
    line    = ((span_sh >> 1) + 11'd7) >> 3;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:      if (req_avail) state_next = B_DIV_START;
      B_DIV_START: state_next = B_DIV_WAIT;
      B_DIV_WAIT: begin
        if (div_done) begin
          if (job == J_YH) begin
            state_next = B_ROW_CHK;
          end else if (job == J_XH) begin
            state_next = B_COL_CHK;
          end else begin
            state_next = B_DIV_START;
          end
        end
      end
      B_ROW_CHK: begin
        if (row_vis) begin
          state_next = B_ROW_FIN;
        end else if (row_done) begin
          state_next = B_FLUSH;
        end else begin
          state_next = B_DIV_START;
        end
      end
      B_ROW_FIN:   state_next = B_DIV_START;
      B_COL_CHK: begin
        if (col_vis) begin
          state_next = B_COL_FIN;
        end else if (col_done && row_done) begin
          state_next = B_FLUSH;
        end else begin
          state_next = B_DIV_START;
        end
      end
      B_COL_FIN:   state_next = B_EMIT;
      B_EMIT: begin
        if (emit_go) begin
          state_next = (col_done && row_done) ? B_FLUSH : B_DIV_START;
        end
      end
      B_FLUSH:     if (emit_go) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    req_pop   = 1'b0;
    div_start = 1'b0;
    case (state)
      B_IDLE:      req_pop = req_avail;
      B_DIV_START: div_start = 1'b1;
      default: begin
        req_pop   = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk position and job: control state
  always_ff @(posedge clk) begin
    if (rst) begin
      job        <= J_DSDX;
      ty         <= '0;
      tx         <= '0;
      held_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= res_load | (res_valid & ~res_ready);
      case (state)
        B_IDLE: begin
          job <= J_DSDX;
          ty  <= '0;
        end
        B_DIV_WAIT: begin
          if (div_done) begin
            case (job)
              J_DSDX:  job <= J_DTDY;
              J_DTDY:  job <= J_YL;
              J_YL:    job <= J_YH;
              J_XL:    job <= J_XH;
              default: job <= job;
            endcase
          end
        end
        B_ROW_CHK: begin
          if (!row_vis) begin
            ty  <= ty_sum[7:0];
            job <= J_YL;
          end
        end
        B_ROW_FIN: begin
          tx  <= '0;
          job <= J_XL;
        end
        B_COL_CHK: begin
          if (!col_vis) begin
            if (col_done) begin
              ty  <= ty_sum[7:0];
              job <= J_YL;
            end else begin
              tx  <= tx_sum[7:0];
              job <= J_XL;
            end
          end
        end
        B_EMIT: begin
          if (emit_go) begin
            held_valid <= 1'b1;
            if (col_done) begin
              ty  <= ty_sum[7:0];
              job <= J_YL;
            end else begin
              tx  <= tx_sum[7:0];
              job <= J_XL;
            end
          end
        end
        B_FLUSH: begin
          if (emit_go && held_valid) begin
            held_valid <= 1'b0;
          end
        end
        default: begin
          job <= job;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (req_avail) begin
          cur <= req;
        end
      end
      B_DIV_WAIT: begin
        if (div_done) begin
          case (job)
            J_DSDX:  dsdx <= div_q;
            J_DTDY:  dtdy <= div_q;
            J_YL:    yl_r <= y_edge;
            J_YH:    yh_r <= y_edge;
            J_XL:    xl_r <= x_edge;
            J_XH:    xh_r <= x_edge;
            default: dsdx <= dsdx;
          endcase
        end
      end
      B_ROW_CHK: prod_r <= yl_r * $signed({1'b0, dtdy});
      B_ROW_FIN: begin
        t_r     <= coord[26:0];
        rt_r    <= (yl_r < 15'sd0) ? 13'd0 : yl_r[12:0];
        rb_r    <= yh_r[13:0];
        lrows_r <= {near_l[6:0], 7'(far_l - 8'd1)};
      end
      B_COL_CHK: prod_r <= xl_r * $signed({1'b0, dsdx});
      B_COL_FIN: begin
        new_r.rect_left   <= (xl_r < 15'sd0) ? 13'd0 : xl_r[12:0];
        new_r.rect_top    <= rt_r;
        new_r.rect_right  <= xh_r[13:0];
        new_r.rect_bottom <= rb_r;
        new_r.s_start     <= coord[26:0];
        new_r.t_start     <= t_r;
        new_r.load_cols   <= {near_l[6:0], 7'(far_l - 8'd1)};
        new_r.load_rows   <= lrows_r;
        new_r.row_words   <= line[6:0];
        new_r.scale_steps <= {dsdx, dtdy};
      end
      B_EMIT: begin
        if (emit_go) begin
          held <= new_r;
          if (held_valid) begin
            res      <= held;
            res_last <= 1'b0;
          end
        end
      end
      B_FLUSH: begin
        if (emit_go && held_valid) begin
          res      <= held;
          res_last <= 1'b1;
        end
      end
      default: begin
        held <= held;
      end
    endcase
  end

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> !held_valid)
    else $error("pending chunk left behind at end of sprite");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == B_DIV_WAIT))
    else $error("divider finished outside a wait");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_COL_CHK) |-> (tx < cur.tw))
    else $error("column walk past texture width");

  a_start_from_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == B_DIV_WAIT))
    else $error("divider started without waiting for it");

endmodule
